@@ design/ssui_pkg.sv @@
// Package for the sorted set union / intersection block.
// Holds the sizing constants, op and status codes and the controller state type.
// No dependencies.
package ssui_pkg;

  // set geometry
  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TOT_W    = $clog2(2 * CAPACITY + 1);

  // fixed field widths on the ports
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int ELEM_W   = 16;
  localparam int COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_UNION     = 2'd1,
    OP_INTERSECT = 2'd2,
    OP_CLEAR     = 2'd3
  } ssui_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ADDED   = 3'd0,
    STAT_PRESENT = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_QUERY   = 3'd3,
    STAT_CLEARED = 3'd4
  } ssui_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_WRITE,
    ST_RESP,
    ST_COUNT,
    ST_EMIT
  } ssui_state_e;

endpackage

@@ design/ssui_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module ssui_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sorted_set_union_intersection.sv @@
// Top level of the sorted set union / intersection block.
// Depends on ssui_pkg and two ssui_ram instances (one per set).
//
//  channel  | dir | tdata (low bit up)                      | tuser              | tlast
//  s_axis   | in  | op[1:0], value[17:2], zero pad to 24    | target_set         | -
//  m_axis   | out | element[15:0], set_count[21:16], pad 24 | status[2:0], empty | last
//
// Insert: a search from the lowest entry, then a shift that moves each larger entry up by
// one, then a write and a response state, paced by the single read and write port of the
// set memory. Union/intersection: a counting walk, then an emitting walk, one memory read
// per pointer per cycle; an empty result goes straight to the response state.
// Clear resets the set count when the request is taken, then responds.
// Output stalls hold the emitting walk; a new request is taken while the last result waits.
// Reset clears the set counts and the controller; set memories need no clearing pass.
module sorted_set_union_intersection
  import ssui_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // op[1:0], value[17:2], zero pad
  input  logic        s_axis_tuser_i,   // target_set
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // element[15:0], set_count[21:16], zero pad
  output logic [3:0]  m_axis_tuser_o,   // status[2:0], empty_result[3]
  output logic        m_axis_tlast_o
);

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  ssui_state_e state_q, state_d;
  logic               union_q, union_d;
  logic               tgt_q, tgt_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   ma_q, ma_d, mb_q, mb_d;
  logic [TOT_W-1:0]   tot_q, tot_d, emit_q, emit_d;
  logic [CNT_W-1:0]   cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  ssui_status_e       rsp_status_q, rsp_status_d;
  logic [COUNT_W-1:0] rsp_cnt_q, rsp_cnt_d;
  logic               rsp_empty_q, rsp_empty_d;

  logic               out_vld_q, out_vld_d;
  ssui_status_e       out_status_q, out_status_d;
  logic [ELEM_W-1:0]  out_elem_q, out_elem_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic               out_empty_q, out_empty_d;
  logic               out_last_q, out_last_d;

  logic               in_accept, out_free;
  ssui_op_e           in_op;
  logic               we_a, we_b, wen;
  logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  logic [VALUE_W-1:0] wdata, rd_a, rd_b, rd_t;
  logic [CNT_W-1:0]   cur_n;

  // merge walk step
  logic               am, bm, hit, adv_a, adv_b, done;
  logic [VALUE_W-1:0] elem;

  // search decision
  logic [CNT_W-1:0]   pos_sel;
  logic               decide;

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign in_op           = ssui_op_e'(s_axis_tdata_i[OP_W-1:0]);
  assign cur_n           = tgt_q ? cnt_b_q : cnt_a_q;
  assign rd_t            = tgt_q ? rd_b : rd_a;

  // set memories
  ssui_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_a),
    .rdata_o(rd_a)
  );

  ssui_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_b),
    .rdata_o(rd_b)
  );

  assign we_a = wen && !tgt_q;
  assign we_b = wen && tgt_q;

  // read addresses follow the next pointer so data lines up with the current one
  always_comb begin
    if (state_d == ST_COUNT || state_d == ST_EMIT) begin
      raddr_a = ma_d[ADDR_W-1:0];
      raddr_b = mb_d[ADDR_W-1:0];
    end else begin
      raddr_a = idx_d[ADDR_W-1:0];
      raddr_b = idx_d[ADDR_W-1:0];
    end
  end

  // one step of the two-pointer walk over A and B
  always_comb begin
    am    = (ma_q < cnt_a_q);
    bm    = (mb_q < cnt_b_q);
    hit   = 1'b0;
    adv_a = 1'b0;
    adv_b = 1'b0;
    done  = 1'b0;
    elem  = rd_a;
    if (am && bm) begin
      if (rd_a == rd_b) begin
        hit   = 1'b1;
        adv_a = 1'b1;
        adv_b = 1'b1;
      end else if (rd_a < rd_b) begin
        hit   = union_q;
        adv_a = 1'b1;
      end else begin
        hit   = union_q;
        adv_b = 1'b1;
        elem  = rd_b;
      end
    end else if (am && union_q) begin
      hit   = 1'b1;
      adv_a = 1'b1;
    end else if (bm && union_q) begin
      hit   = 1'b1;
      adv_b = 1'b1;
      elem  = rd_b;
    end else begin
      done = 1'b1;
    end
  end

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    union_d      = union_q;
    tgt_d        = tgt_q;
    val_d        = val_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    ma_d         = ma_q;
    mb_d         = mb_q;
    tot_d        = tot_q;
    emit_d       = emit_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    rsp_status_d = rsp_status_q;
    rsp_cnt_d    = rsp_cnt_q;
    rsp_empty_d  = rsp_empty_q;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_elem_d   = out_elem_q;
    out_cnt_d    = out_cnt_q;
    out_empty_d  = out_empty_q;
    out_last_d   = out_last_q;
    wen          = 1'b0;
    waddr        = idx_q[ADDR_W-1:0];
    wdata        = rd_t;
    pos_sel      = cur_n;
    decide       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          tgt_d   = s_axis_tuser_i;
          val_d   = s_axis_tdata_i[OP_W +: VALUE_W];
          union_d = (in_op == OP_UNION);
          idx_d   = '0;
          ma_d    = '0;
          mb_d    = '0;
          tot_d   = '0;
          unique case (in_op)
            OP_INSERT: state_d = ST_SEARCH;
            OP_CLEAR: begin
              if (s_axis_tuser_i) begin
                cnt_b_d = '0;
              end else begin
                cnt_a_d = '0;
              end
              rsp_status_d = STAT_CLEARED;
              rsp_cnt_d    = '0;
              rsp_empty_d  = 1'b0;
              state_d      = ST_RESP;
            end
            OP_UNION, OP_INTERSECT: state_d = ST_COUNT;
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_SEARCH: begin
        if (idx_q >= cur_n) begin
          pos_sel = cur_n;
          decide  = 1'b1;
        end else if (rd_t == val_q) begin
          rsp_status_d = STAT_PRESENT;
          rsp_cnt_d    = COUNT_W'(cur_n);
          rsp_empty_d  = 1'b0;
          state_d      = ST_RESP;
        end else if (val_q < rd_t) begin
          pos_sel = idx_q;
          decide  = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
        // position known: drop when full, else shift or write directly
        if (decide) begin
          pos_d = pos_sel;
          if (cur_n >= CapCnt) begin
            rsp_status_d = STAT_FULL;
            rsp_cnt_d    = COUNT_W'(cur_n);
            rsp_empty_d  = 1'b0;
            state_d      = ST_RESP;
          end else if (pos_sel == cur_n) begin
            state_d = ST_WRITE;
          end else begin
            idx_d   = cur_n - 1'b1;
            state_d = ST_SHIFT;
          end
        end
      end

      // move entry idx up by one, walking down to the insert position
      ST_SHIFT: begin
        wen   = 1'b1;
        waddr = ADDR_W'(idx_q + 1'b1);
        wdata = rd_t;
        if (idx_q == pos_q) begin
          state_d = ST_WRITE;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end

      ST_WRITE: begin
        wen   = 1'b1;
        waddr = pos_q[ADDR_W-1:0];
        wdata = val_q;
        if (tgt_q) begin
          cnt_b_d = cur_n + 1'b1;
        end else begin
          cnt_a_d = cur_n + 1'b1;
        end
        rsp_status_d = STAT_ADDED;
        rsp_cnt_d    = COUNT_W'(cur_n + 1'b1);
        rsp_empty_d  = 1'b0;
        state_d      = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = rsp_status_q;
          out_elem_d   = '0;
          out_cnt_d    = rsp_cnt_q;
          out_empty_d  = rsp_empty_q;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      // first walk: size the result
      ST_COUNT: begin
        if (done) begin
          if (tot_q == '0) begin
            rsp_status_d = STAT_QUERY;
            rsp_cnt_d    = '0;
            rsp_empty_d  = 1'b1;
            state_d      = ST_RESP;
          end else begin
            ma_d    = '0;
            mb_d    = '0;
            emit_d  = '0;
            state_d = ST_EMIT;
          end
        end else begin
          tot_d = tot_q + TOT_W'(hit);
          ma_d  = ma_q + CNT_W'(adv_a);
          mb_d  = mb_q + CNT_W'(adv_b);
        end
      end

      // second walk: emit each element, held while the output stalls
      ST_EMIT: begin
        if (out_free && !done) begin
          ma_d = ma_q + CNT_W'(adv_a);
          mb_d = mb_q + CNT_W'(adv_b);
          if (hit) begin
            out_vld_d    = 1'b1;
            out_status_d = STAT_QUERY;
            out_elem_d   = ELEM_W'(elem);
            out_cnt_d    = COUNT_W'(tot_q);
            out_empty_d  = 1'b0;
            out_last_d   = (emit_q + 1'b1 == tot_q);
            emit_d       = emit_q + 1'b1;
            if (emit_q + 1'b1 == tot_q) begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    union_q      <= union_d;
    tgt_q        <= tgt_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    ma_q         <= ma_d;
    mb_q         <= mb_d;
    tot_q        <= tot_d;
    emit_q       <= emit_d;
    rsp_status_q <= rsp_status_d;
    rsp_cnt_q    <= rsp_cnt_d;
    rsp_empty_q  <= rsp_empty_d;
    out_status_q <= out_status_d;
    out_elem_q   <= out_elem_d;
    out_cnt_q    <= out_cnt_d;
    out_empty_q  <= out_empty_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_cnt_q, out_elem_q};
  assign m_axis_tuser_o  = {out_empty_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

  // set counts stay within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CapCnt) && (cnt_b_q <= CapCnt))
    else $error("set count above capacity");

  // memories are written only by the shift and the final insert write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wen |-> (state_q == ST_SHIFT || state_q == ST_WRITE))
    else $error("set memory written outside an insert");

  // a shift never moves an entry from outside the filled range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (idx_q < cur_n) && (idx_q >= pos_q))
    else $error("shift source out of range");

  // the emitting walk never passes the counted size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (emit_q < tot_q) && !done)
    else $error("emit walk ran past the result size");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_set_union_intersection: streams insert, clear and query requests
// and checks every result against a behavioral copy of both sorted sets.
// Depends on ssui_pkg and the block's top level.
module tb;
  import ssui_pkg::*;

  typedef struct packed {
    ssui_op_e    op;
    logic        target;
    logic [15:0] value;
  } set_request_t;

  typedef struct packed {
    ssui_status_e status;
    logic [15:0]  element;
    logic [5:0]   count;
    logic         empty;
    logic         last;
  } set_result_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data  = '0;
  logic        s_user  = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic [3:0]  m_user;
  logic        m_last;

  // behavioral copy of both sets, index 0 is set A and 1 is set B
  logic [15:0] set_vals [0:1][0:CAPACITY-1];
  int          set_cnt  [0:1];

  set_request_t request_q [$];
  set_result_t  result_q  [$];
  set_request_t cur_req = '0;
  set_result_t  want;
  int           errors = 0;
  int           send_idle = 22;
  int           recv_idle = 79;

  sorted_set_union_intersection dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // op[1:0], value[17:2], zero pad
    .s_axis_tuser_i  (s_user),   // target_set
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // element[15:0], set_count[21:16], zero pad
    .m_axis_tuser_o  (m_user),   // status[2:0], empty_result[3]
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one accepted request to the set copy and queue the results it causes
  task automatic apply_set_request(set_request_t req);
    int          t, n, pos, m, o;
    bit          done;
    ssui_status_e st;
    logic [15:0] x, y;
    logic [15:0] hits [$];
    t = req.target;
    case (req.op)
      OP_INSERT: begin
        n    = set_cnt[t];
        pos  = n;
        st   = STAT_ADDED;
        done = 1'b0;
        // a duplicate is found before the full check
        for (int j = 0; j < n && !done; j++) begin
          if (set_vals[t][j] == req.value) begin
            st   = STAT_PRESENT;
            done = 1'b1;
          end else if (req.value < set_vals[t][j]) begin
            pos  = j;
            done = 1'b1;
          end
        end
        if (st == STAT_ADDED && n >= CAPACITY) st = STAT_FULL;
        if (st == STAT_ADDED) begin
          for (int j = n; j > pos; j--) set_vals[t][j] = set_vals[t][j-1];
          set_vals[t][pos] = req.value;
          set_cnt[t] = n + 1;
        end
        result_q.push_back('{st, 16'd0, 6'(set_cnt[t]), 1'b0, 1'b1});
      end
      OP_CLEAR: begin
        set_cnt[t] = 0;
        result_q.push_back('{STAT_CLEARED, 16'd0, 6'd0, 1'b0, 1'b1});
      end
      default: begin
        // two-pointer walk over both sets
        m = 0;
        o = 0;
        while (m < set_cnt[0] && o < set_cnt[1]) begin
          x = set_vals[0][m];
          y = set_vals[1][o];
          if (x == y) begin
            hits.push_back(x);
            m++;
            o++;
          end else if (x < y) begin
            if (req.op == OP_UNION) hits.push_back(x);
            m++;
          end else begin
            if (req.op == OP_UNION) hits.push_back(y);
            o++;
          end
        end
        if (req.op == OP_UNION) begin
          while (m < set_cnt[0]) begin
            hits.push_back(set_vals[0][m]);
            m++;
          end
          while (o < set_cnt[1]) begin
            hits.push_back(set_vals[1][o]);
            o++;
          end
        end
        if (hits.size() == 0) begin
          result_q.push_back('{STAT_QUERY, 16'd0, 6'd0, 1'b1, 1'b1});
        end else begin
          foreach (hits[k]) begin
            result_q.push_back('{STAT_QUERY, hits[k], 6'(hits.size()), 1'b0,
                                 (k == hits.size() - 1)});
          end
        end
      end
    endcase
  endtask

  task automatic push_req(ssui_op_e op, logic tgt, logic [15:0] value);
    request_q.push_back('{op, tgt, value});
  endtask

  // Mostly insert bursts into one set, usually from a value window, mixed with queries; some noise
  task automatic add_random_requests(int budget);
    int          added, kind, len, base;
    logic        tgt;
    logic [15:0] value;
    added = 0;
    while (added < budget) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        tgt = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0) begin
          push_req(OP_CLEAR, tgt, 16'($urandom));
          added++;
        end
        len = $urandom_range(1, 20);
        case ($urandom_range(0, 3))
          0:       base = 0;
          1:       base = 16'h7fe8;
          2:       base = 16'hffd0;
          default: base = -1;
        endcase
        repeat (len) begin
          if (base < 0) value = 16'($urandom);
          else          value = 16'(base + $urandom_range(0, 47));
          push_req(OP_INSERT, tgt, value);
          added++;
        end
      end else if (kind < 8) begin
        push_req($urandom_range(0, 1) ? OP_UNION : OP_INTERSECT, 1'($urandom),
                 16'($urandom));
        added++;
      end else begin
        push_req(ssui_op_e'(2'($urandom_range(0, 3))), 1'($urandom), 16'($urandom));
        added++;
      end
    end
  endtask

  // Offer the next request; hand each accepted one to the set copy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (s_valid) apply_set_request(cur_req);
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        cur_req = request_q.pop_front();
        s_data  <= {6'd0, cur_req.value, cur_req.op};
        s_user  <= cur_req.target;
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d element %h count %0d empty %0b last %0b",
                 $time, m_user[2:0], m_data[15:0], m_data[21:16], m_user[3], m_last);
      end else begin
        want = result_q.pop_front();
        if (m_user[2:0] !== want.status || m_data[15:0] !== want.element ||
            m_data[21:16] !== want.count || m_user[3] !== want.empty ||
            m_last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected status %0d element %h count %0d empty %0b last %0b",
                   $time, want.status, want.element, want.count, want.empty, want.last);
          $display("%0t:          actual status %0d element %h count %0d empty %0b last %0b",
                   $time, m_user[2:0], m_data[15:0], m_data[21:16], m_user[3], m_last);
        end
      end
    end
  end

  initial begin
    set_cnt[0] = 0;
    set_cnt[1] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty queries, extremes, duplicate, single-element results
    push_req(OP_UNION,     1'b0, 16'hffff);
    push_req(OP_INTERSECT, 1'b1, 16'h0000);
    push_req(OP_INSERT,    1'b0, 16'h0000);
    push_req(OP_INSERT,    1'b0, 16'hffff);
    push_req(OP_INSERT,    1'b0, 16'h0000);
    push_req(OP_INSERT,    1'b1, 16'hffff);
    push_req(OP_INTERSECT, 1'b0, 16'h5a5a);
    push_req(OP_UNION,     1'b1, 16'ha5a5);
    push_req(OP_CLEAR,     1'b0, 16'hffff);
    push_req(OP_CLEAR,     1'b1, 16'h0000);
    // fill set A in descending order so every insert after the first shifts all entries
    for (int i = 0; i < CAPACITY; i++) push_req(OP_INSERT, 1'b0, 16'(16'hf000 - 16'h0f0f * i));
    // new value into the full set, then a duplicate in the full set
    push_req(OP_INSERT,    1'b0, 16'h0007);
    push_req(OP_INSERT,    1'b0, 16'hf000);
    push_req(OP_UNION,     1'b0, 16'h0000);
    push_req(OP_INTERSECT, 1'b0, 16'h0000);
    add_random_requests(110);
    while (request_q.size() != 0) @(posedge clk_i);

    send_idle = 79;
    recv_idle = 22;
    add_random_requests(115);
    while (request_q.size() != 0) @(posedge clk_i);

    send_idle = 0;
    recv_idle = 0;
    add_random_requests(115);

    // drain: all requests accepted, all results seen, then a settling margin
    while (request_q.size() != 0 || s_valid) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
